// ===== rtl/core/quaternion_to_roll_pitch_core_assert.svh =====
// Assertion macros shared by the quaternion to roll and pitch RTL.
// Needs a clock named clk and an active-low reset named arst_n where used.
`ifndef QUATERNION_TO_ROLL_PITCH_CORE_ASSERT_SVH
`define QUATERNION_TO_ROLL_PITCH_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define QRP_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("qrp: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define QRP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("qrp: next-cycle check failed");

`endif

// ===== rtl/core/qrp_pkg.sv =====
// Package for the quaternion to roll and pitch core: datapath widths,
// CORDIC constants and the angle rounding helpers. No dependencies.
package qrp_pkg;

	// Quaternion component width (Q2.14) and matrix term width (28 fraction bits).
	localparam int QUAT_W  = 16;
	localparam int TERM_W  = 34;
	// CORDIC datapath width and angle width (20 fraction bits).
	localparam int CORDIC_W = 36;
	localparam int ANG_W    = 24;
	// Output angle widths (roll Q3.13, pitch Q2.13).
	localparam int ROLL_W   = 16;
	localparam int PITCH_W  = 15;
	// Rounded angle width before saturation.
	localparam int RND_W    = 18;

	// Largest supported iteration count, i.e. the depth of the arctangent table.
	localparam int MAX_STEPS = 24;

	localparam logic signed [ANG_W-1:0] HALF_PI_Q20 = 24'sd1647099;
	localparam logic [25:0] INV_GAIN_Q26 = 26'd40752055;
	localparam logic signed [RND_W-1:0] ROLL_LIMIT  = 18'sd25736;
	localparam logic signed [RND_W-1:0] PITCH_LIMIT = 18'sd12868;

	// atan(2^-i) at 20 fraction bits, rounded to nearest.
	localparam logic signed [ANG_W-1:0] ATAN_TAB [MAX_STEPS] = '{
		24'sd823550, 24'sd486170, 24'sd256879, 24'sd130396,
		24'sd65451,  24'sd32757,  24'sd16383,  24'sd8192,
		24'sd4096,   24'sd2048,   24'sd1024,   24'sd512,
		24'sd256,    24'sd128,    24'sd64,     24'sd32,
		24'sd16,     24'sd8,      24'sd4,      24'sd2,
		24'sd1,      24'sd0,      24'sd0,      24'sd0
	};

	// Round a 20-fraction-bit angle to 13 fraction bits, half towards plus
	// infinity, then clamp it symmetrically to the given limit.
	function automatic logic signed [RND_W-1:0] round_sat(
		input logic signed [ANG_W-1:0] a,
		input logic signed [RND_W-1:0] limit
	);
		logic signed [ANG_W:0] t;
		logic signed [RND_W-1:0] r;
		t = {a[ANG_W-1], a} + 25'sd64;
		r = t[ANG_W:7];
		if (r > limit) begin
			r = limit;
		end else if (r < -limit) begin
			r = -limit;
		end
		return r;
	endfunction

endpackage

// ===== rtl/core/quaternion_to_roll_pitch_core.sv =====
// Quaternion to roll and pitch angles.
// Slave stream: one beat carries a quaternion w, x, y, z in signed Q2.14.
// Master stream: one beat carries pitch (Q2.13, within +/- pi/2) and roll
// (Q3.13, within +/- pi), one result beat for every input beat, in order.
// The datapath is a fully pipelined chain: matrix products and sums, a CORDIC
// vectoring pipeline for roll and the magnitude, a two-stage gain correction,
// a second CORDIC pipeline for pitch, and an output register with a skid slot.
// A beat is taken on every cycle while s_tready is high, so the throughput is
// one quaternion per clock. Each result passes through the matrix, CORDIC,
// gain and output registers before it appears on m_tvalid; the two CORDIC
// pipelines have CORDIC_STEPS + 1 stages each.
// Reset clears every valid bit and the skid slot; no result is pending after it.
// When the receiver holds m_tready low the skid slot takes one more beat, after
// which s_tready falls and the whole pipeline freezes without losing a beat.
// Depends on qrp_pkg, the assertion macro header, qrp_matrix, qrp_cordic, qrp_gain and qrp_skid.
module quaternion_to_roll_pitch_core #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [63:0] s_tdata,    // quat_w [15:0], quat_x [31:16], quat_y [47:32], quat_z [63:48]
	output logic m_tvalid,
	input  logic m_tready,
	output logic [31:0] m_tdata     // pitch_angle [14:0], roll_angle [30:15], zero [31]
);

	`include "quaternion_to_roll_pitch_core_assert.svh"

	localparam int QW   = qrp_pkg::QUAT_W;
	localparam int TW   = qrp_pkg::TERM_W;
	localparam int CW   = qrp_pkg::CORDIC_W;
	localparam int AW   = qrp_pkg::ANG_W;
	localparam int RW   = qrp_pkg::ROLL_W;
	localparam int PW   = qrp_pkg::PITCH_W;
	localparam int OUT_W = 32;

	logic en;
	logic mat_valid, c1_valid, g_valid, c2_valid;
	logic signed [TW-1:0] r31, r32, r33;
	logic signed [CW-1:0] c1_x, c1_y, neg_r31, c1_out_x, c2_in_y, mag, c2_out_x;
	logic signed [AW-1:0] roll_raw, roll_ang, pitch_ang;
	logic [CW-1:0] c1_side;
	logic [AW+CW-1:0] g_side;
	logic [AW-1:0] c2_side;
	logic signed [qrp_pkg::RND_W-1:0] roll_r, pitch_r;
	logic [OUT_W-1:0] res_data;

	// The whole pipeline advances while the skid slot is free.
	assign s_tready = en;

	qrp_matrix u_matrix (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_tvalid),
		.quat_w    ($signed(s_tdata[QW-1:0])),
		.quat_x    ($signed(s_tdata[2*QW-1:QW])),
		.quat_y    ($signed(s_tdata[3*QW-1:2*QW])),
		.quat_z    ($signed(s_tdata[4*QW-1:3*QW])),
		.out_valid (mat_valid),
		.r31       (r31),
		.r32       (r32),
		.r33       (r33)
	);

	// Roll: angle of (R33, R32); the magnitude feeds the pitch stage.
	assign c1_x    = CW'(r33);
	assign c1_y    = CW'(r32);
	assign neg_r31 = -CW'(r31);

	qrp_cordic #(
		.STEPS  (CORDIC_STEPS),
		.SIDE_W (CW)
	) u_cordic_roll (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (mat_valid),
		.in_x      (c1_x),
		.in_y      (c1_y),
		.in_side   (neg_r31),
		.out_valid (c1_valid),
		.out_x     (c1_out_x),
		.out_ang   (roll_raw),
		.out_side  (c1_side)
	);

	qrp_gain #(
		.SIDE_W (AW + CW)
	) u_gain (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (c1_valid),
		.in_x      (c1_out_x),
		.in_side   ({roll_raw, c1_side}),
		.out_valid (g_valid),
		.out_mag   (mag),
		.out_side  (g_side)
	);

	// Pitch: angle of (magnitude, -R31).
	assign c2_in_y = $signed(g_side[CW-1:0]);

	qrp_cordic #(
		.STEPS  (CORDIC_STEPS),
		.SIDE_W (AW)
	) u_cordic_pitch (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (g_valid),
		.in_x      (mag),
		.in_y      (c2_in_y),
		.in_side   (g_side[AW+CW-1:CW]),
		.out_valid (c2_valid),
		.out_x     (c2_out_x),
		.out_ang   (pitch_ang),
		.out_side  (c2_side)
	);

	// Round both angles to 13 fraction bits and clamp them to their ranges.
	assign roll_ang = $signed(c2_side);
	assign roll_r   = qrp_pkg::round_sat(roll_ang, qrp_pkg::ROLL_LIMIT);
	assign pitch_r  = qrp_pkg::round_sat(pitch_ang, qrp_pkg::PITCH_LIMIT);
	assign res_data = {1'b0, roll_r[RW-1:0], pitch_r[PW-1:0]};

	qrp_skid #(
		.W (OUT_W)
	) u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (c2_valid),
		.in_ready  (en),
		.in_data   (res_data),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata)
	);

	// A frozen pipeline means a result is waiting on the master side.
	`QRP_ASSERT_NOW(a_frozen_has_output, !s_tready, m_tvalid)
	// The pipeline only freezes after the receiver stalled a presented beat.
	`QRP_ASSERT_NOW(a_freeze_cause, $fell(s_tready), $past(m_tvalid && !m_tready))
	// Delivered angles stay within their clamps and the pad bit is clear.
	`QRP_ASSERT_NOW(a_out_range, m_tvalid,
		!m_tdata[31]
		&& $signed(m_tdata[30:15]) <= 16'sd25736 && $signed(m_tdata[30:15]) >= -16'sd25736
		&& $signed(m_tdata[14:0]) <= 15'sd12868 && $signed(m_tdata[14:0]) >= -15'sd12868)
	// After pre-rotation and gain correction the CORDIC x never goes negative.
	`QRP_ASSERT_NOW(a_cordic_x_pos, c2_valid, !c2_out_x[CW-1] && !mag[CW-1])

endmodule

// ===== rtl/core/qrp_matrix.sv =====
// Rotation-matrix terms R31, R32 and R33 from one quaternion, in two stages:
// products first, then the sums. Depends on qrp_pkg.
module qrp_matrix (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_valid,
	input  logic signed [qrp_pkg::QUAT_W-1:0] quat_w,
	input  logic signed [qrp_pkg::QUAT_W-1:0] quat_x,
	input  logic signed [qrp_pkg::QUAT_W-1:0] quat_y,
	input  logic signed [qrp_pkg::QUAT_W-1:0] quat_z,
	output logic out_valid,
	output logic signed [qrp_pkg::TERM_W-1:0] r31,
	output logic signed [qrp_pkg::TERM_W-1:0] r32,
	output logic signed [qrp_pkg::TERM_W-1:0] r33
);

	localparam int PW = 2 * qrp_pkg::QUAT_W;
	localparam int TW = qrp_pkg::TERM_W;

	logic valid_s1, valid_s2;
	logic signed [PW-1:0] wy_s1, xz_s1, wx_s1, yz_s1, ww_s1, xx_s1, yy_s1, zz_s1;
	logic signed [TW-1:0] r31_s2, r32_s2, r33_s2;

	// Valid bits move with the data whenever the pipeline advances.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	// Stage one: the eight exact products.
	always_ff @(posedge clk) begin
		if (en) begin
			wy_s1 <= quat_w * quat_y;
			xz_s1 <= quat_x * quat_z;
			wx_s1 <= quat_w * quat_x;
			yz_s1 <= quat_y * quat_z;
			ww_s1 <= quat_w * quat_w;
			xx_s1 <= quat_x * quat_x;
			yy_s1 <= quat_y * quat_y;
			zz_s1 <= quat_z * quat_z;
		end
	end

	// Stage two: sums and differences, doubled where the formula says so.
	always_ff @(posedge clk) begin
		if (en) begin
			r31_s2 <= (TW'(xz_s1) - TW'(wy_s1)) <<< 1;
			r32_s2 <= (TW'(wx_s1) + TW'(yz_s1)) <<< 1;
			r33_s2 <= TW'(ww_s1) + TW'(zz_s1) - TW'(xx_s1) - TW'(yy_s1);
		end
	end

	assign out_valid = valid_s2;
	assign r31 = r31_s2;
	assign r32 = r32_s2;
	assign r33 = r33_s2;

endmodule

// ===== rtl/core/qrp_cordic.sv =====
// Pipelined CORDIC vectoring unit: one quadrant pre-rotation stage, then one
// register stage per iteration. Carries a sideband word alongside. Uses qrp_pkg.
module qrp_cordic #(
	parameter int STEPS  = 16,
	parameter int SIDE_W = 24
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_valid,
	input  logic signed [qrp_pkg::CORDIC_W-1:0] in_x,
	input  logic signed [qrp_pkg::CORDIC_W-1:0] in_y,
	input  logic [SIDE_W-1:0] in_side,
	output logic out_valid,
	output logic signed [qrp_pkg::CORDIC_W-1:0] out_x,
	output logic signed [qrp_pkg::ANG_W-1:0] out_ang,
	output logic [SIDE_W-1:0] out_side
);

	localparam int CW = qrp_pkg::CORDIC_W;
	localparam int AW = qrp_pkg::ANG_W;

	logic                 valid_s [STEPS+1];
	logic                 zero_s  [STEPS+1];
	logic signed [CW-1:0] x_s     [STEPS+1];
	logic signed [CW-1:0] y_s     [STEPS+1];
	logic signed [AW-1:0] z_s     [STEPS+1];
	logic [SIDE_W-1:0]    side_s  [STEPS+1];

	logic signed [CW-1:0] pre_x, pre_y;
	logic signed [AW-1:0] pre_z;

	// A vector in the left half-plane is first turned by a quarter turn.
	always_comb begin
		pre_x = in_x;
		pre_y = in_y;
		pre_z = '0;
		if (in_x < 0) begin
			if (in_y >= 0) begin
				pre_x = in_y;
				pre_y = -in_x;
				pre_z = qrp_pkg::HALF_PI_Q20;
			end else begin
				pre_x = -in_y;
				pre_y = in_x;
				pre_z = -qrp_pkg::HALF_PI_Q20;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s[0] <= 1'b0;
		end else if (en) begin
			valid_s[0] <= in_valid;
		end
	end

	// Stage zero: pre-rotated vector and the zero-vector mark.
	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0]    <= pre_x;
			y_s[0]    <= pre_y;
			z_s[0]    <= pre_z;
			zero_s[0] <= (in_x == '0) && (in_y == '0);
			side_s[0] <= in_side;
		end
	end

	// One micro-rotation per stage, steered by the sign of y.
	for (genvar k = 0; k < STEPS; k++) begin : g_iter
		localparam logic signed [AW-1:0] ATAN_K = qrp_pkg::ATAN_TAB[k];
		logic signed [CW-1:0] dx, dy;

		assign dx = y_s[k] >>> k;
		assign dy = x_s[k] >>> k;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k+1] <= 1'b0;
			end else if (en) begin
				valid_s[k+1] <= valid_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (!y_s[k][CW-1]) begin
					x_s[k+1] <= x_s[k] + dx;
					y_s[k+1] <= y_s[k] - dy;
					z_s[k+1] <= z_s[k] + ATAN_K;
				end else begin
					x_s[k+1] <= x_s[k] - dx;
					y_s[k+1] <= y_s[k] + dy;
					z_s[k+1] <= z_s[k] - ATAN_K;
				end
				zero_s[k+1] <= zero_s[k];
				side_s[k+1] <= side_s[k];
			end
		end
	end

	// The zero vector has angle zero; its x stays zero through every step.
	assign out_valid = valid_s[STEPS];
	assign out_x     = x_s[STEPS];
	assign out_ang   = zero_s[STEPS] ? '0 : z_s[STEPS];
	assign out_side  = side_s[STEPS];

endmodule

// ===== rtl/core/qrp_gain.sv =====
// CORDIC gain correction: x times 1/K at 26 fraction bits, rounded, split
// into two partial products over two stages. Uses qrp_pkg.
module qrp_gain #(
	parameter int SIDE_W = 60
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_valid,
	input  logic signed [qrp_pkg::CORDIC_W-1:0] in_x,
	input  logic [SIDE_W-1:0] in_side,
	output logic out_valid,
	output logic signed [qrp_pkg::CORDIC_W-1:0] out_mag,
	output logic [SIDE_W-1:0] out_side
);

	localparam int CW   = qrp_pkg::CORDIC_W;
	localparam int LO_W = 18;
	localparam int HI_W = CW - LO_W;
	localparam int KW   = 26;
	localparam int SUM_W = 64;

	logic valid_s1, valid_s2;
	logic [LO_W+KW-1:0]        p_lo_s1;
	logic signed [HI_W+KW:0]   p_hi_s1;
	logic [SIDE_W-1:0]         side_s1, side_s2;
	logic signed [CW-1:0]      mag_s2;
	logic signed [SUM_W-1:0]   sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	// Stage one: low and high partial products against the constant.
	always_ff @(posedge clk) begin
		if (en) begin
			p_lo_s1 <= in_x[LO_W-1:0] * qrp_pkg::INV_GAIN_Q26;
			p_hi_s1 <= $signed(in_x[CW-1:LO_W]) * $signed({1'b0, qrp_pkg::INV_GAIN_Q26});
			side_s1 <= in_side;
		end
	end

	// Stage two: recombine, add one half and drop the 26 fraction bits.
	always_comb begin
		sum = ($signed({{(SUM_W-HI_W-KW-1){p_hi_s1[HI_W+KW]}}, p_hi_s1}) <<< LO_W)
			+ $signed({{(SUM_W-LO_W-KW){1'b0}}, p_lo_s1})
			+ 64'sd33554432;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s2  <= sum[KW+CW-1:KW];
			side_s2 <= side_s1;
		end
	end

	assign out_valid = valid_s2;
	assign out_mag   = mag_s2;
	assign out_side  = side_s2;

endmodule

// ===== rtl/core/qrp_skid.sv =====
// Output register with one skid entry, so that the upstream ready comes
// from a flop. No package dependencies.
module qrp_skid #(
	parameter int W = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [W-1:0] in_data,
	output logic out_valid,
	input  logic out_ready,
	output logic [W-1:0] out_data
);

	logic out_valid_q, skid_valid_q;
	logic [W-1:0] out_data_q, skid_data_q;
	logic load;

	assign load     = out_ready || !out_valid_q;
	assign in_ready = !skid_valid_q;

	// Output slot refills from the skid entry first, then from upstream.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q  <= skid_valid_q || in_valid;
			skid_valid_q <= 1'b0;
		end else if (in_valid && in_ready) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_data_q <= skid_valid_q ? skid_data_q : in_data;
		end else if (in_valid && in_ready) begin
			skid_data_q <= in_data;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for quaternion_to_roll_pitch_core: drives quaternion beats,
// predicts pitch and roll with a CORDIC model of its own and checks each result beat.
// Depends on the core RTL and qrp_pkg (compiled alongside); needs no files at run time.
module tb_top;

	localparam int STEPS       = 16;
	localparam int CYCLE_LIMIT = 400000;
	localparam int RAND_ITEMS  = 132;
	localparam int N_ROWS      = 24;

	// CORDIC constants at 20 fraction bits, and the gain correction at 26.
	localparam longint HALF_PI_Q20 = 1647099;
	localparam longint INV_GAIN    = 40752055;
	localparam longint ROLL_MAX    = 25736;
	localparam longint PITCH_MAX   = 12868;
	localparam longint ATAN_Q20 [24] = '{
		823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192,
		4096, 2048, 1024, 512, 256, 128, 64, 32,
		16, 8, 4, 2, 1, 0, 0, 0
	};

	// Idling per phase, in percent: none, sender, receiver, both.
	localparam int TX_IDLE [4]  = '{0, 54, 0, 29};
	localparam int RX_STALL [4] = '{0, 0, 54, 29};

	typedef struct packed {
		logic signed [14:0] pitch;
		logic signed [15:0] roll;
	} angles_t;

	typedef struct packed {
		logic signed [15:0] w;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
		logic               has_known;
		angles_t            known;
	} quat_row_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata  = '0;      // quat_w, quat_x, quat_y, quat_z from bit 0 up
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;            // pitch_angle, roll_angle, zero pad from bit 0 up

	angles_t angle_q [$];
	int      errors      = 0;
	int      cycle_count = 0;
	int      tx_idle_pct = 0;
	int      rx_stall_pct = 0;

	// Directed rows: zero quaternion, identity, extremes of each field, quarter
	// turns, roll at and either side of plus or minus pi, and gimbal lock.
	quat_row_t dir_rows [N_ROWS] = '{
		'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, '{15'sd0, 16'sd0}},
		'{16'sd16384, 16'sd0, 16'sd0, 16'sd0, 1'b0, '{15'sd0, 16'sd0}},
		'{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 1'b0, '{15'sd0, 16'sd0}},
		'{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 1'b0, '{15'sd0, 16'sd0}},
		'{16'sd32767, 16'sd0, 16'sd0, 16'sd0, 1'b0, '{15'sd0, 16'sd0}},
		'{16'sh8000, 16'sd0, 16'sd0, 16'sd0, 1'b0, '{15'sd0, 16'sd0}},
		'{16'sd0, 16'sd32767, 16'sd0, 16'sd0, 1'b0, '{15'sd0, 16'sd0}},
		'{16'sd0, 16'sh8000, 16'sd0, 16'sd0, 1'b0, '{15'sd0, 16'sd0}},
		'{16'sd0, 16'sd0, 16'sd32767, 16'sd0, 1'b0, '{15'sd0, 16'sd0}},
		'{16'sd0, 16'sd0, 16'sh8000, 16'sd0, 1'b0, '{15'sd0, 16'sd0}},
		'{16'sd0, 16'sd0, 16'sd0, 16'sd32767, 1'b0, '{15'sd0, 16'sd0}},
		'{16'sd0, 16'sd0, 16'sd0, 16'sh8000, 1'b0, '{15'sd0, 16'sd0}},
		'{16'sd11585, 16'sd11585, 16'sd0, 16'sd0, 1'b0, '{15'sd0, 16'sd0}},
		'{16'sd11585, -16'sd11585, 16'sd0, 16'sd0, 1'b0, '{15'sd0, 16'sd0}},
		'{16'sd11585, 16'sd0, 16'sd11585, 16'sd0, 1'b0, '{15'sd0, 16'sd0}},
		'{16'sd11585, 16'sd0, -16'sd11585, 16'sd0, 1'b0, '{15'sd0, 16'sd0}},
		'{16'sd0, 16'sd16384, 16'sd0, 16'sd0, 1'b0, '{15'sd0, 16'sd0}},
		'{-16'sd1, 16'sd16384, 16'sd0, 16'sd0, 1'b0, '{15'sd0, 16'sd0}},
		'{16'sd1, 16'sd16384, 16'sd0, 16'sd0, 1'b0, '{15'sd0, 16'sd0}},
		'{16'sd8192, 16'sd4096, 16'sd8192, -16'sd4096, 1'b0, '{15'sd0, 16'sd0}},
		'{16'sd1, 16'sd0, 16'sd0, 16'sd0, 1'b0, '{15'sd0, 16'sd0}},
		'{-16'sd1, -16'sd1, -16'sd1, -16'sd1, 1'b0, '{15'sd0, 16'sd0}},
		'{16'sd9459, 16'sd9459, 16'sd9459, 16'sd9459, 1'b0, '{15'sd0, 16'sd0}},
		'{16'sd32767, 16'sh8000, 16'sd32767, 16'sh8000, 1'b0, '{15'sd0, 16'sd0}}
	};

	quaternion_to_roll_pitch_core #(
		.CORDIC_STEPS(STEPS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	// Clock with a period of ten units.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// CORDIC vectoring: angle of (x, y) at 20 fraction bits and the
	// gain-corrected magnitude. The shifts floor, as arithmetic shifts do.
	function automatic void cordic_vectoring(input longint x_in, input longint y_in,
			output longint ang, output longint mag);
		longint xv, yv, zv, dx, dy, t;
		xv = x_in;
		yv = y_in;
		zv = 0;
		if (xv == 0 && yv == 0) begin
			ang = 0;
			mag = 0;
			return;
		end
		// Vectors in the left half-plane are first turned by a quarter turn.
		if (xv < 0) begin
			t = xv;
			if (yv >= 0) begin
				xv = yv;
				yv = -t;
				zv = HALF_PI_Q20;
			end else begin
				xv = -yv;
				yv = t;
				zv = -HALF_PI_Q20;
			end
		end
		for (int i = 0; i < STEPS; i++) begin
			dx = yv >>> i;
			dy = xv >>> i;
			if (yv >= 0) begin
				xv = xv + dx;
				yv = yv - dy;
				zv = zv + ATAN_Q20[i];
			end else begin
				xv = xv - dx;
				yv = yv + dy;
				zv = zv - ATAN_Q20[i];
			end
		end
		ang = zv;
		mag = (xv * INV_GAIN + (64'sd1 <<< 25)) >>> 26;
	endfunction

	// Round from 20 to 13 fraction bits, half upwards, then clamp symmetrically.
	function automatic longint round_to_q13(input longint a, input longint limit);
		longint r;
		r = (a + 64) >>> 7;
		if (r > limit) begin
			r = limit;
		end else if (r < -limit) begin
			r = -limit;
		end
		return r;
	endfunction

	// Roll and pitch of one quaternion from its rotation-matrix terms.
	function automatic angles_t predict_angles(input logic signed [15:0] qw, qx, qy, qz);
		longint w, x, y, z, r31, r32, r33, roll_a, mag, pitch_a, spare;
		angles_t res;
		w = qw;
		x = qx;
		y = qy;
		z = qz;
		r31 = 2 * (x * z - w * y);
		r32 = 2 * (w * x + y * z);
		r33 = w * w - x * x - y * y + z * z;
		cordic_vectoring(r33, r32, roll_a, mag);
		cordic_vectoring(mag, -r31, pitch_a, spare);
		res.pitch = 15'(round_to_q13(pitch_a, PITCH_MAX));
		res.roll  = 16'(round_to_q13(roll_a, ROLL_MAX));
		return res;
	endfunction

	// Offer one quaternion beat after a random gap and queue its expected angles
	// at the edge where it is taken.
	task automatic send_quat(input logic signed [15:0] w, x, y, z,
			input logic use_known, input angles_t known);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {z, y, x, w};
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
		if (use_known) begin
			angle_q.insert(angle_q.size(), known);
		end else begin
			angle_q.insert(angle_q.size(), predict_angles(w, x, y, z));
		end
	endtask

	// Receiver back-pressure, drawn afresh on every edge.
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= rx_stall_pct);
	end

	// Compare every result beat with the oldest expected angles.
	always @(posedge clk) begin
		angles_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (angle_q.size() == 0) begin
				$display("%0t unexpected result beat: actual pitch %0d roll %0d", $time,
					$signed(m_tdata[14:0]), $signed(m_tdata[30:15]));
				errors++;
			end else begin
				want = angle_q.pop_front();
				if (m_tdata[14:0] !== want.pitch) begin
					$display("%0t pitch mismatch: expected %0d, actual %0d", $time,
						want.pitch, $signed(m_tdata[14:0]));
					errors++;
				end
				if (m_tdata[30:15] !== want.roll) begin
					$display("%0t roll mismatch: expected %0d, actual %0d", $time,
						want.roll, $signed(m_tdata[30:15]));
					errors++;
				end
			end
		end
	end

	// Watchdog on the length of the run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("quaternion_to_roll_pitch_core regression: fail");
			$finish;
		end
	end

	// Stimulus: reset, the directed rows, then four phases of random beats.
	initial begin
		logic signed [15:0] qw, qx, qy, qz;
		int pick, a, b;
		angles_t no_known;
		no_known = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < N_ROWS; r++) begin
			send_quat(dir_rows[r].w, dir_rows[r].x, dir_rows[r].y, dir_rows[r].z,
				dir_rows[r].has_known, dir_rows[r].known);
		end

		for (int ph = 0; ph < 4; ph++) begin
			tx_idle_pct  = TX_IDLE[ph];
			rx_stall_pct = RX_STALL[ph];
			for (int n = 0; n < RAND_ITEMS; n++) begin
				pick = $urandom_range(99);
				a = $urandom_range(32768) - 16384;
				b = $urandom_range(32768) - 16384;
				{qz, qy, qx, qw} = {$urandom, $urandom};
				if (pick < 15) begin
					// Full-range components, mostly far from unit length.
				end else if (pick < 60) begin
					// Components within plus or minus one.
					qw = 16'(a);
					qx = 16'(b);
					qy = 16'($urandom_range(32768) - 16384);
					qz = 16'($urandom_range(32768) - 16384);
				end else if (pick < 80) begin
					// Axis-like quaternions with some components zeroed.
					if ($urandom_range(9) < 6) qw = '0;
					if ($urandom_range(9) < 6) qx = '0;
					if ($urandom_range(9) < 6) qy = '0;
					if ($urandom_range(9) < 6) qz = '0;
				end else begin
					// Gimbal lock: roll terms vanish and pitch sits at a quarter turn.
					qw = 16'(a);
					qx = 16'(b);
					if ($urandom_range(1) == 0) begin
						qy = 16'(a);
						qz = 16'(-b);
					end else begin
						qy = 16'(-a);
						qz = 16'(b);
					end
				end
				send_quat(qw, qx, qy, qz, 1'b0, no_known);
			end
			// The sender holds off until every result of the phase is in.
			s_tvalid <= 1'b0;
			while (angle_q.size() != 0) begin
				@(posedge clk);
			end
		end

		repeat (2 * STEPS + 20) @(posedge clk);
		if (errors == 0) begin
			$display("quaternion_to_roll_pitch_core regression: pass");
		end else begin
			$display("quaternion_to_roll_pitch_core regression: fail");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/qrp_pkg.sv
rtl/core/qrp_matrix.sv
rtl/core/qrp_cordic.sv
rtl/core/qrp_gain.sv
rtl/core/qrp_skid.sv
rtl/core/quaternion_to_roll_pitch_core.sv
tb/tb_top.sv
